// ===== hw/rtl/glyph_text_to_display_stream_defines.svh =====
// ----------------------------------------------------------------------------
// Glyph text renderer assertion macros
// Shared wrappers for the concurrent checks on the renderer ports.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXT_TO_DISPLAY_STREAM_DEFINES_SVH
`define GLYPH_TEXT_TO_DISPLAY_STREAM_DEFINES_SVH

// A check that must hold in the same cycle as its condition.
`define GTTD_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A check whose consequence must hold in the cycle after its condition.
`define GTTD_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

// ===== hw/rtl/gttd_pkg.sv =====
// ----------------------------------------------------------------------------
// Glyph text renderer package
// Font table, command byte constants and the record passed from front to back.
// ----------------------------------------------------------------------------
package gttd_pkg;

	// Font table geometry and character range.
	localparam int RomRows    = 92;
	localparam int RomCols    = 6;
	localparam int GlyphCount = 92;
	localparam logic [6:0] FirstCode = 7'd32;

	// Cursor wraps to the next page once the column passes this value.
	localparam logic [7:0] WrapLimit = 8'd122;

	// Controller position command bytes.
	localparam logic [7:0] PageCmd   = 8'hB0;
	localparam logic [7:0] ColHiCmd  = 8'h10;
	localparam logic [7:0] ColLoMask = 8'h0F;
	localparam logic [7:0] ColHiMask = 8'hF0;

	// Number of position command bytes ahead of the glyph bytes.
	localparam int PosBytes = 3;

	// Depth of the queue between the front and back ends.
	localparam int CmdQDepth = 2;

	// One classified character: where to draw it and which glyph to use.
	typedef struct packed {
		logic [2:0] page;
		logic [7:0] column;
		logic       blank;
		logic [6:0] glyph_idx;
	} gttd_cmd_t;

	// Font rows; the leftmost byte of each row is pixel column 0.
	localparam logic [47:0] FontRom [RomRows] = '{
		48'h000000000000, 48'h0000002f0000, 48'h000007000700, 48'h00147f147f14,
		48'h00242a7f2a12, 48'h006264081323, 48'h003649552250, 48'h000005030000,
		48'h00001c224100, 48'h000041221c00, 48'h0014083E0814, 48'h0008083E0808,
		48'h000000A06000, 48'h000808080808, 48'h000060600000, 48'h002010080402,
		48'h003E5149453E, 48'h0000427F4000, 48'h004261514946, 48'h002141454B31,
		48'h001814127F10, 48'h002745454539, 48'h003C4A494930, 48'h000171090503,
		48'h003649494936, 48'h00064949291E, 48'h000036360000, 48'h000056360000,
		48'h000814224100, 48'h001414141414, 48'h000041221408, 48'h000201510906,
		48'h00324959513E, 48'h007C1211127C, 48'h007F49494936, 48'h003E41414122,
		48'h007F4141221C, 48'h007F49494941, 48'h007F09090901, 48'h003E4149497A,
		48'h007F0808087F, 48'h0000417F4100, 48'h002040413F01, 48'h007F08142241,
		48'h007F40404040, 48'h007F020C027F, 48'h007F0408107F, 48'h003E4141413E,
		48'h007F09090906, 48'h003E4151215E, 48'h007F09192946, 48'h004649494931,
		48'h0001017F0101, 48'h003F4040403F, 48'h001F2040201F, 48'h003F4038403F,
		48'h006314081463, 48'h000708700807, 48'h006151494543, 48'h00007F414100,
		48'h000204081020, 48'h000041417F00, 48'h000402010204, 48'h004040404040,
		48'h000001020400, 48'h002054545478, 48'h007F48444438, 48'h003844444420,
		48'h00384444487F, 48'h003854545418, 48'h00087E090102, 48'h0018A4A4A47C,
		48'h007F08040478, 48'h0000447D4000, 48'h004080847D00, 48'h007F10284400,
		48'h0000417F4000, 48'h007C04180478, 48'h007C08040478, 48'h003844444438,
		48'h00FC24242418, 48'h0018242418FC, 48'h007C08040408, 48'h004854545420,
		48'h00043F444020, 48'h003C4040207C, 48'h001C2040201C, 48'h003C4030403C,
		48'h004428102844, 48'h001CA0A0A07C, 48'h004464544C44, 48'h141414141414
	};

	// One pixel column of a glyph; positions beyond the table read as zero.
	function automatic logic [7:0] glyph_byte(input logic [6:0] idx, input logic [2:0] pos);
		logic [47:0] row;
		logic [7:0]  result;
		row    = '0;
		result = '0;
		if ((7'(idx) < 7'(RomRows)) && (3'(pos) < 3'(RomCols))) begin
			row    = FontRom[idx];
			result = row[(RomCols - 1 - int'(pos)) * 8 +: 8];
		end
		return result;
	endfunction

endpackage

// ===== hw/rtl/gttd_front.sv =====
// ----------------------------------------------------------------------------
// Glyph text renderer front end
// Keeps the text cursor, applies wrapping and classifies each character.
// ----------------------------------------------------------------------------
module gttd_front #(
	parameter int GLYPH_WIDTH = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [6:0]          char_code,
	input  logic                start_string,
	input  logic [6:0]          start_column,
	input  logic [2:0]          start_page,
	output gttd_pkg::gttd_cmd_t cmd
);

	logic [7:0] cursor_column_q;
	logic [2:0] cursor_page_q;
	logic [7:0] base_column;
	logic [2:0] base_page;
	logic [7:0] draw_column;
	logic [2:0] draw_page;
	logic [6:0] idx;

	// Pick the starting position, then wrap past the right edge.
	always_comb begin
		base_column = start_string ? {1'b0, start_column} : cursor_column_q;
		base_page   = start_string ? start_page : cursor_page_q;
		if (base_column > gttd_pkg::WrapLimit) begin
			draw_column = '0;
			draw_page   = base_page + 3'd1;
		end else begin
			draw_column = base_column;
			draw_page   = base_page;
		end
	end

	// Classify the character: codes without a glyph draw blank.
	always_comb begin
		idx            = char_code - gttd_pkg::FirstCode;
		cmd.page       = draw_page;
		cmd.column     = draw_column;
		cmd.glyph_idx  = idx;
		cmd.blank      = (char_code < gttd_pkg::FirstCode)
			|| (9'(idx) >= 9'(gttd_pkg::GlyphCount))
			|| (9'(idx) >= 9'(gttd_pkg::RomRows));
	end

	// Advance the cursor by one glyph for every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_column_q <= '0;
			cursor_page_q   <= '0;
		end else if (take) begin
			cursor_column_q <= draw_column + 8'(GLYPH_WIDTH);
			cursor_page_q   <= draw_page;
		end
	end

endmodule

// ===== hw/rtl/gttd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Glyph text renderer command queue
// Short queue of classified characters between the front and back ends.
// ----------------------------------------------------------------------------
module gttd_cmd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  gttd_pkg::gttd_cmd_t wr_data,
	output logic                full,
	input  logic                rd_en,
	output gttd_pkg::gttd_cmd_t rd_data,
	output logic                empty
);

	localparam int PtrW = $clog2(gttd_pkg::CmdQDepth);
	localparam int CntW = $clog2(gttd_pkg::CmdQDepth + 1);

	gttd_pkg::gttd_cmd_t mem_q [gttd_pkg::CmdQDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (count_q == CntW'(gttd_pkg::CmdQDepth));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Pointer and occupancy tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(gttd_pkg::CmdQDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(gttd_pkg::CmdQDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hw/rtl/gttd_back.sv =====
// ----------------------------------------------------------------------------
// Glyph text renderer back end
// Turns each queued character into position command bytes and glyph bytes.
// ----------------------------------------------------------------------------
module gttd_back #(
	parameter int GLYPH_WIDTH = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gttd_pkg::gttd_cmd_t q_data,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output logic [7:0]          out_byte,
	output logic                is_data,
	output logic                last_byte
);

	localparam int LastIdx = gttd_pkg::PosBytes + GLYPH_WIDTH - 1;
	localparam int CntW    = $clog2(LastIdx + 1);

	gttd_pkg::gttd_cmd_t cmd_q;
	logic                busy_q;
	logic [CntW-1:0]     cnt_q;
	logic                out_valid_q;
	logic                adv;
	logic                at_last;
	logic [7:0]          byte_d;
	logic [3:0]          pos;

	assign adv     = !out_valid_q || pop;
	assign at_last = (cnt_q == CntW'(LastIdx));
	assign q_pop   = !q_empty && (!busy_q || (adv && at_last));
	assign empty   = !out_valid_q;

	// Select the byte for the current position in the character.
	always_comb begin
		pos    = 4'(cnt_q) - 4'(gttd_pkg::PosBytes);
		byte_d = '0;
		if (cnt_q == CntW'(0)) begin
			byte_d = gttd_pkg::PageCmd + {5'd0, cmd_q.page};
		end else if (cnt_q == CntW'(1)) begin
			byte_d = gttd_pkg::ColHiCmd | ((cmd_q.column & gttd_pkg::ColHiMask) >> 4);
		end else if (cnt_q == CntW'(2)) begin
			byte_d = cmd_q.column & gttd_pkg::ColLoMask;
		end else if (!cmd_q.blank && (pos < 4'(gttd_pkg::RomCols))) begin
			byte_d = gttd_pkg::glyph_byte(cmd_q.glyph_idx, pos[2:0]);
		end
	end

	// Sequencer control and output register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!busy_q) begin
				if (adv) begin
					out_valid_q <= 1'b0;
				end
				if (!q_empty) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (adv) begin
				out_valid_q <= 1'b1;
				if (at_last) begin
					busy_q <= !q_empty;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Character record and output payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
		if (busy_q && adv) begin
			out_byte  <= byte_d;
			is_data   <= (cnt_q >= CntW'(gttd_pkg::PosBytes));
			last_byte <= at_last;
		end
	end

endmodule

// ===== hw/rtl/glyph_text_to_display_stream.sv =====
// ----------------------------------------------------------------------------
// Glyph text to display stream
// 6x8 text renderer producing position commands and glyph bytes for a
// page-addressed display controller.
// ----------------------------------------------------------------------------
// Each accepted character yields 3 + GLYPH_WIDTH bytes (nine by default): the
// page command, the column high and low commands, then the glyph columns, with
// last_byte marking the final one. While pop is held high and characters are
// queued, the back end emits one byte per cycle, with no gap between characters;
// a two-entry command queue lets up to two further characters be accepted
// ahead. From idle, a character passes the queue and the character record
// before its first byte is registered. The cursor wraps to column 0 of the next
// page past column 122, pages wrap from 7 to 0, codes without a glyph draw blank.
module glyph_text_to_display_stream #(
	parameter int GLYPH_WIDTH = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [6:0] char_code,
	input  logic       start_string,
	input  logic [6:0] start_column,
	input  logic [2:0] start_page,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       is_data,
	output logic       last_byte
);

	gttd_pkg::gttd_cmd_t front_cmd;
	gttd_pkg::gttd_cmd_t q_data;
	logic                take;
	logic                q_empty;
	logic                q_pop;

	assign take = push && !full;

	// Front end: cursor tracking and classification.
	gttd_front #(
		.GLYPH_WIDTH(GLYPH_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.char_code   (char_code),
		.start_string(start_string),
		.start_column(start_column),
		.start_page  (start_page),
		.cmd         (front_cmd)
	);

	// Queue between front and back ends.
	gttd_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (take),
		.wr_data(front_cmd),
		.full   (full),
		.rd_en  (q_pop),
		.rd_data(q_data),
		.empty  (q_empty)
	);

	// Back end: byte sequencing and output register.
	gttd_back #(
		.GLYPH_WIDTH(GLYPH_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_data   (q_data),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.is_data  (is_data),
		.last_byte(last_byte)
	);

endmodule

// ===== hw/rtl/gttd_checker.sv =====
// ----------------------------------------------------------------------------
// Glyph text renderer port checker
// Watches the result port for correct per-character byte framing.
// ----------------------------------------------------------------------------
`include "glyph_text_to_display_stream_defines.svh"

module gttd_checker #(
	parameter int GLYPH_WIDTH = 6
) (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       is_data,
	input logic       last_byte
);

	localparam int LastIdx = gttd_pkg::PosBytes + GLYPH_WIDTH - 1;
	localparam int CntW    = $clog2(LastIdx + 1);

	logic [CntW-1:0] idx_q;

	// Position of the shown byte within its character, counted per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (pop && !empty) begin
			idx_q <= last_byte ? '0 : idx_q + 1'b1;
		end
	end

	`GTTD_CHECK(a_page_first, (!empty && idx_q == '0) |-> (out_byte[7:3] == 5'b10110 && !is_data), "character does not open with a page command")
	`GTTD_CHECK(a_last_place, !empty |-> (last_byte == (idx_q == CntW'(LastIdx))), "last_byte out of place")
	`GTTD_CHECK(a_data_class, !empty |-> (is_data == (idx_q >= CntW'(gttd_pkg::PosBytes))), "is_data does not match byte position")
	`GTTD_CHECK_NEXT(a_hold, (!empty && !pop), (!empty && $stable(out_byte) && $stable(last_byte)), "stalled result changed")

endmodule

bind glyph_text_to_display_stream gttd_checker #(
	.GLYPH_WIDTH(GLYPH_WIDTH)
) u_gttd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.out_byte (out_byte),
	.is_data  (is_data),
	.last_byte(last_byte)
);

// ===== sim/tb_glyph_text_to_display_stream.sv =====
// ----------------------------------------------------------------------------
// Glyph text to display stream testbench
// Drives characters into the renderer and checks every command and glyph byte
// it emits against a cycle-free prediction of the cursor and the font table.
// Both sides idle at random. One phase holds the receiver off so that the
// block stalls its input, and another pauses the sender until all bytes are out.
// ----------------------------------------------------------------------------
module tb_glyph_text_to_display_stream;

	localparam int GLYPH_WIDTH     = 6;
	localparam int CLK_PERIOD      = 8;
	localparam int RESET_CYCLES    = 6;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int DRAIN_CYCLES    = 20;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int MAX_REPORTS     = 10;

	// Character range, cursor wrap point and position command bytes.
	localparam int         FIRST_GLYPH = 32;
	localparam int         GLYPH_COUNT = 92;
	localparam int         FONT_COLS   = 6;
	localparam logic [7:0] COL_WRAP    = 8'd122;
	localparam logic [7:0] PAGE_CMD    = 8'hB0;
	localparam logic [7:0] COL_HI_CMD  = 8'h10;

	// Font table; the leftmost byte of each row is pixel column 0.
	localparam logic [47:0] FONT_COLUMNS [GLYPH_COUNT] = '{
		48'h000000000000, 48'h0000002f0000, 48'h000007000700, 48'h00147f147f14,
		48'h00242a7f2a12, 48'h006264081323, 48'h003649552250, 48'h000005030000,
		48'h00001c224100, 48'h000041221c00, 48'h0014083e0814, 48'h0008083e0808,
		48'h000000a06000, 48'h000808080808, 48'h000060600000, 48'h002010080402,
		48'h003e5149453e, 48'h0000427f4000, 48'h004261514946, 48'h002141454b31,
		48'h001814127f10, 48'h002745454539, 48'h003c4a494930, 48'h000171090503,
		48'h003649494936, 48'h00064949291e, 48'h000036360000, 48'h000056360000,
		48'h000814224100, 48'h001414141414, 48'h000041221408, 48'h000201510906,
		48'h00324959513e, 48'h007c1211127c, 48'h007f49494936, 48'h003e41414122,
		48'h007f4141221c, 48'h007f49494941, 48'h007f09090901, 48'h003e4149497a,
		48'h007f0808087f, 48'h0000417f4100, 48'h002040413f01, 48'h007f08142241,
		48'h007f40404040, 48'h007f020c027f, 48'h007f0408107f, 48'h003e4141413e,
		48'h007f09090906, 48'h003e4151215e, 48'h007f09192946, 48'h004649494931,
		48'h0001017f0101, 48'h003f4040403f, 48'h001f2040201f, 48'h003f4038403f,
		48'h006314081463, 48'h000708700807, 48'h006151494543, 48'h00007f414100,
		48'h000204081020, 48'h000041417f00, 48'h000402010204, 48'h004040404040,
		48'h000001020400, 48'h002054545478, 48'h007f48444438, 48'h003844444420,
		48'h00384444487f, 48'h003854545418, 48'h00087e090102, 48'h0018a4a4a47c,
		48'h007f08040478, 48'h0000447d4000, 48'h004080847d00, 48'h007f10284400,
		48'h0000417f4000, 48'h007c04180478, 48'h007c08040478, 48'h003844444438,
		48'h00fc24242418, 48'h0018242418fc, 48'h007c08040408, 48'h004854545420,
		48'h00043f444020, 48'h003c4040207c, 48'h001c2040201c, 48'h003c4030403c,
		48'h004428102844, 48'h001ca0a0a07c, 48'h004464544c44, 48'h141414141414
	};

	// One byte as the display controller sees it.
	typedef struct packed {
		logic [7:0] value;
		logic       is_data;
		logic       last;
	} disp_byte_t;

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       push         = 1'b0;
	logic       full;
	logic [6:0] char_code    = '0;
	logic       start_string = 1'b0;
	logic [6:0] start_column = '0;
	logic [2:0] start_page   = '0;
	logic       empty;
	logic       pop          = 1'b0;
	logic [7:0] out_byte;
	logic       is_data;
	logic       last_byte;

	// Predicted text cursor and the bytes still owed by the block.
	logic [7:0] cur_column = '0;
	logic [2:0] cur_page   = '0;
	disp_byte_t expected_bytes [$];

	int mismatches      = 0;
	int rx_hold_request = 0;
	bit tx_steady       = 1'b0;
	bit rx_steady       = 1'b0;

	glyph_text_to_display_stream #(
		.GLYPH_WIDTH(GLYPH_WIDTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.char_code(char_code),
		.start_string(start_string),
		.start_column(start_column),
		.start_page(start_page),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.is_data(is_data),
		.last_byte(last_byte)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Pixel column of a glyph; codes without a glyph and positions past the
	// font width read as zero.
	function automatic logic [7:0] glyph_column(input logic [6:0] code, input int pos);
		int row;
		row = int'(code) - FIRST_GLYPH;
		if (row < 0 || row >= GLYPH_COUNT || pos >= FONT_COLS)
			return 8'h00;
		return FONT_COLUMNS[row][(FONT_COLS - 1 - pos) * 8 +: 8];
	endfunction

	// Advance the cursor for one character and queue the bytes it draws.
	function automatic void predict_char_bytes(input logic [6:0] code, input logic start,
			input logic [6:0] col, input logic [2:0] page);
		int total;
		total = 3 + GLYPH_WIDTH;
		if (start) begin
			cur_column = {1'b0, col};
			cur_page   = page;
		end
		// Past the right edge the cursor moves to the start of the next page.
		if (cur_column > COL_WRAP) begin
			cur_column = '0;
			cur_page   = cur_page + 3'd1;
		end
		expected_bytes.push_back('{PAGE_CMD + {5'd0, cur_page}, 1'b0, total == 1});
		expected_bytes.push_back('{COL_HI_CMD | {4'h0, cur_column[7:4]}, 1'b0, total == 2});
		expected_bytes.push_back('{{4'h0, cur_column[3:0]}, 1'b0, total == 3});
		for (int i = 0; i < GLYPH_WIDTH; i++)
			expected_bytes.push_back('{glyph_column(code, i), 1'b1, i == GLYPH_WIDTH - 1});
		cur_column = cur_column + 8'(GLYPH_WIDTH);
	endfunction

	// Mostly no gap, sometimes a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Mostly characters that have a glyph, the rest anything at all.
	function automatic logic [6:0] pick_code();
		if ($urandom_range(0, 9) == 0)
			return 7'($urandom_range(0, 127));
		return 7'($urandom_range(FIRST_GLYPH, FIRST_GLYPH + GLYPH_COUNT - 1));
	endfunction

	// Offer one character, wait for the transaction, then idle at random.
	task automatic send_char(input logic [6:0] code, input logic start,
			input logic [6:0] col, input logic [2:0] page);
		int gap;
		push         <= 1'b1;
		char_code    <= code;
		start_string <= start;
		start_column <= col;
		start_page   <= page;
		do @(posedge clk); while (full);
		predict_char_bytes(code, start, col, page);
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random strings: a start position followed by a run of characters whose
	// start fields carry noise that the block must ignore.
	task automatic send_strings(input int count);
		int sent;
		int len;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 12);
			for (int k = 0; k < len; k++) begin
				send_char(pick_code(), k == 0, 7'($urandom_range(0, 127)),
					3'($urandom_range(0, 7)));
				sent++;
			end
		end
	endtask

	// Field extremes, both kinds of item and every wrap case.
	task automatic test_directed();
		send_char(7'd65, 1'b0, 7'd0, 3'd0);
		send_char(7'd0, 1'b0, 7'h7f, 3'd7);
		send_char(7'd31, 1'b0, 7'd0, 3'd0);
		send_char(7'd32, 1'b0, 7'd0, 3'd0);
		send_char(7'd123, 1'b0, 7'd0, 3'd0);
		send_char(7'd124, 1'b0, 7'd0, 3'd0);
		send_char(7'd127, 1'b0, 7'd0, 3'd0);
		send_char(7'd33, 1'b1, 7'd0, 3'd0);
		// Column 122 still draws; the next character wraps from page 7 to 0.
		send_char(7'd72, 1'b1, 7'd122, 3'd7);
		send_char(7'd105, 1'b0, 7'd0, 3'd0);
		// Start columns past the edge wrap at once.
		send_char(7'd87, 1'b1, 7'd123, 3'd3);
		send_char(7'd119, 1'b1, 7'd127, 3'd7);
		send_char(7'd90, 1'b1, 7'd117, 3'd5);
		send_char(7'd122, 1'b0, 7'd0, 3'd0);
		send_char(7'd48, 1'b0, 7'd0, 3'd0);
		send_char(7'd64, 1'b1, 7'h55, 3'd2);
		send_char(7'd42, 1'b1, 7'h2a, 3'd5);
		send_char(7'd126, 1'b0, 7'h2a, 3'd5);
		send_char(7'd1, 1'b0, 7'h55, 3'd2);
	endtask

	task automatic test_strings();
		send_strings(110);
	endtask

	// Every field fully random, including codes without a glyph.
	task automatic test_noise();
		repeat (60)
			send_char(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
				7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
	endtask

	// No idling on either side, so the block runs at its full rate.
	task automatic test_back_to_back();
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		send_strings(40);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// The receiver holds off while the sender keeps offering, so the block
	// fills up and raises full.
	task automatic test_hold_off();
		rx_hold_request = HOLD_OFF_CYCLES;
		tx_steady       = 1'b1;
		send_strings(20);
		tx_steady       = 1'b0;
	endtask

	// The sender stops until every byte has come out, then resumes.
	task automatic test_drain_pause();
		send_strings(10);
		push <= 1'b0;
		do @(posedge clk); while (expected_bytes.size() != 0);
		send_strings(10);
	endtask

	// Check each output transaction and decide when to take the next one.
	initial begin : byte_checker
		disp_byte_t want;
		int         rx_gap;
		int         hold_left;
		rx_gap    = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("ERROR: unexpected byte %02h is_data=%0b last_byte=%0b",
							out_byte, is_data, last_byte);
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.value || is_data !== want.is_data ||
							last_byte !== want.last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("ERROR: expected %02h/%0b/%0b, got %02h/%0b/%0b",
								want.value, want.is_data, want.last,
								out_byte, is_data, last_byte);
					end
				end
				rx_gap = rx_steady ? 0 : pick_gap();
			end
			if (rx_hold_request != 0) begin
				hold_left       = rx_hold_request;
				rx_hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// End the run once nothing has moved on either side for too long.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("glyph_text_to_display_stream test failed");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_strings();
		test_noise();
		test_back_to_back();
		test_hold_off();
		test_drain_pause();

		// Let the last bytes drain, then watch for any stray output.
		push <= 1'b0;
		do @(posedge clk); while (expected_bytes.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("glyph_text_to_display_stream test passed");
		else
			$display("glyph_text_to_display_stream test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/gttd_pkg.sv
hw/rtl/gttd_front.sv
hw/rtl/gttd_cmd_fifo.sv
hw/rtl/gttd_back.sv
hw/rtl/glyph_text_to_display_stream.sv
hw/rtl/gttd_checker.sv
sim/tb_glyph_text_to_display_stream.sv
